>>> design/hbpc_pkg.sv
// Package for the histogram black point clip block: widths, codes, FSM states.
// No dependencies.
package hbpc_pkg;
  localparam int unsigned HistBins  = 65536;
  localparam int unsigned MaxPixels = 16777216;
  localparam int unsigned ChW       = 16;
  localparam logic [15:0] NotFoundLevel = 16'hFFFF;
  localparam logic        RegFraction = 1'b0;
  localparam logic        RegMaxValue = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HRD, ST_HWR, ST_WALK_RD, ST_WALK, ST_DONE, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_wr;     // write zero at clear address
    logic clr_inc;    // advance address counter
    logic clr_start;  // reset address counter
    logic load_px;    // capture input pixel
    logic hist_rd;    // read bin of captured pixel
    logic hist_wr;    // write incremented bin
    logic walk_start; // start walk
    logic walk_step;  // accumulate one bin
    logic set_level;  // latch black level
    logic div_start;  // start dividers
    logic out_load;   // load output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;   // clear counter at last bin
    logic px_last;    // captured pixel carries last
    logic px_apply;   // captured pixel is apply pass
    logic walk_hit;   // walk found a qualifying bin
    logic walk_end;   // walk at last bin
    logic div_done;   // dividers finished
  } sts_t;
endpackage

>>> design/hbpc_if.sv
// Valid/ready stream interface with generic payload.
// Depends on nothing.
interface hbpc_if #(parameter int unsigned W = 1) (input logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/hbpc_ram.sv
// Generic single port RAM with registered read.
// Depends on nothing.
module hbpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> design/hbpc_ctrl.sv
// Controller FSM: sequences clear, histogram update, walk and apply.
// Depends on hbpc_pkg.
module hbpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  input  hbpc_pkg::sts_t sts_i,
  output hbpc_pkg::cmd_t cmd_o
);
  import hbpc_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:    if (in_valid_i) state_d = ST_HRD;
      ST_HRD:     state_d = sts_i.px_apply ? ST_DIV : ST_HWR;
      ST_HWR:     state_d = sts_i.px_last ? ST_WALK_RD : ST_IDLE;
      ST_WALK_RD: state_d = ST_WALK;
      ST_WALK:    if (sts_i.walk_hit || sts_i.walk_end) state_d = ST_DONE;
      ST_DONE:    state_d = ST_CLEAR;
      ST_DIV:     if (sts_i.div_done) state_d = ST_OUT;
      ST_OUT:     if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin cmd_o.clr_wr = 1'b1; cmd_o.clr_inc = 1'b1; end
      ST_IDLE: begin in_ready_o = 1'b1; cmd_o.load_px = in_valid_i; end
      ST_HRD: begin cmd_o.hist_rd = 1'b1; cmd_o.div_start = sts_i.px_apply; end
      ST_HWR: begin
        cmd_o.hist_wr = 1'b1;
        cmd_o.walk_start = sts_i.px_last;
      end
      ST_WALK_RD: cmd_o.clr_inc = 1'b1;
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.clr_inc = 1'b1;
      end
      ST_DONE: begin cmd_o.set_level = 1'b1; cmd_o.clr_start = 1'b1; end
      ST_DIV:  ;
      ST_OUT:  cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end
endmodule

>>> design/hbpc_dp.sv
// Datapath: bin memory, pixel total, walk accumulator, brightness and
// three iterative dividers for the stretch. Depends on hbpc_pkg, hbpc_ram.
module hbpc_dp #(
  parameter int unsigned HistBinsP  = hbpc_pkg::HistBins,
  parameter int unsigned MaxPixelsP = hbpc_pkg::MaxPixels
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hbpc_pkg::cmd_t cmd_i,
  output hbpc_pkg::sts_t sts_o,
  input  logic [15:0]    fraction_i,
  input  logic [15:0]    max_value_i,
  input  logic [49:0]    in_data_i,
  output logic [64:0]    res_o
);
  import hbpc_pkg::*;
  localparam int unsigned AW = $clog2(HistBinsP);
  localparam int unsigned CW = $clog2(MaxPixelsP) + 1;
  localparam int unsigned LW = CW + 16;

  logic          act_q, last_q;
  logic [15:0]   r_q, g_q, b_q;
  logic [18:0]   sum6;
  logic [15:0]   br_now;
  logic [15:0]   br_q;
  logic [AW-1:0] addr_q, ram_addr, bin_idx;
  logic [CW-1:0] total_q, ram_rd, ram_wd;
  logic          ram_we;
  logic [LW-1:0] limit_q, cum_q, cum_n;
  logic [15:0]   level_q;

  // pixel capture; brightness by divide-by-6 on 19-bit sum (reciprocal, exact below 2^19)
  assign sum6   = {2'b0, r_q, 1'b0} + {3'b0, g_q} + {2'b0, b_q, 1'b0};
  assign br_now = 16'(({18'd0, sum6} * 37'd174763) >> 20);
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      act_q  <= in_data_i[49];
      r_q    <= in_data_i[48:33];
      g_q    <= in_data_i[32:17];
      b_q    <= in_data_i[16:1];
      last_q <= in_data_i[0];
    end
    if (cmd_i.hist_rd) br_q <= br_now;
  end
  assign sts_o.px_last  = last_q;
  assign sts_o.px_apply = act_q;

  assign bin_idx = (32'(br_now) > HistBinsP - 1) ? AW'(HistBinsP - 1) : AW'(br_now);
  logic [AW-1:0] bin_q;
  always_ff @(posedge clk_i) if (cmd_i.hist_rd) bin_q <= bin_idx;

  wire counting = (total_q < CW'(MaxPixelsP));
  always_comb begin
    ram_we   = 1'b0;
    ram_wd   = '0;
    ram_addr = addr_q;
    if (cmd_i.clr_wr) ram_we = 1'b1;
    else if (cmd_i.hist_rd) ram_addr = bin_idx;
    else if (cmd_i.hist_wr) begin
      ram_addr = bin_q;
      ram_we   = counting;
      ram_wd   = ram_rd + CW'(1);
    end
  end

  hbpc_ram #(.Width(CW), .Depth(HistBinsP)) u_bins (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // address counter for clear and walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) addr_q <= '0;
    else if (cmd_i.clr_start || cmd_i.walk_start) addr_q <= '0;
    else if (cmd_i.clr_inc) addr_q <= addr_q + AW'(1);
  end
  assign sts_o.clr_last = cmd_i.clr_wr && (addr_q == AW'(HistBinsP - 1));

  // pixel total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) total_q <= '0;
    else if (cmd_i.set_level) total_q <= '0;
    else if (cmd_i.hist_wr && counting) total_q <= total_q + CW'(1);
  end

  // walk: ram_rd holds bin (addr-1) during walk_step
  logic [AW-1:0] widx_q;
  assign cum_n = cum_q + LW'(ram_rd);
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      limit_q <= LW'(fraction_i) * LW'(total_q + CW'(counting));
      cum_q   <= '0;
      widx_q  <= '0;
    end else if (cmd_i.walk_step) begin
      cum_q  <= cum_n;
      widx_q <= widx_q + AW'(1);
    end
  end
  assign sts_o.walk_hit = cmd_i.walk_step && ({cum_n, 16'd0} > {16'd0, limit_q});
  assign sts_o.walk_end = widx_q == AW'(HistBinsP - 1);
  logic hit_q;
  always_ff @(posedge clk_i) if (cmd_i.walk_step) hit_q <= sts_o.walk_hit;
  logic [AW-1:0] hidx_q;
  always_ff @(posedge clk_i) if (cmd_i.walk_step) hidx_q <= widx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) level_q <= '0;
    else if (cmd_i.set_level) level_q <= hit_q ? 16'(hidx_q) : NotFoundLevel;
  end

  // stretch: restoring dividers, one quotient bit per cycle
  logic [31:0] num_q [3];
  logic [16:0] rem_q [3];
  logic [31:0] quo_q [3];
  logic [15:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  wire  [15:0] diff = br_q - level_q;
  wire  [15:0] ch [3] = '{r_q, g_q, b_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin busy_q <= 1'b0; cnt_q <= '0; end
    else if (cmd_i.div_start) begin busy_q <= 1'b1; cnt_q <= 6'd33; end
    else if (busy_q && cnt_q != 0) cnt_q <= cnt_q - 6'd1;
    else busy_q <= 1'b0;
  end
  assign sts_o.div_done = busy_q && cnt_q == 0;
  always_ff @(posedge clk_i) begin
    if (cnt_q == 6'd33) den_q <= max_value_i - level_q;
    for (int k = 0; k < 3; k++) begin
      logic [16:0] t;
      t = {rem_q[k][15:0], num_q[k][31]};
      if (cnt_q == 6'd33) begin
        num_q[k] <= ch[k] * diff;
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end else if (busy_q && cnt_q != 0) begin
        num_q[k] <= num_q[k] << 1;
        if (t >= {1'b0, den_q}) begin
          rem_q[k] <= t - {1'b0, den_q};
          quo_q[k] <= {quo_q[k][30:0], 1'b1};
        end else begin
          rem_q[k] <= t;
          quo_q[k] <= {quo_q[k][30:0], 1'b0};
        end
      end
    end
  end

  // final selection
  logic [15:0] o [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (br_q < level_q) o[k] = '0;
      else if (max_value_i <= level_q) o[k] = (br_q > level_q) ? max_value_i : '0;
      else if (quo_q[k] > {16'd0, max_value_i}) o[k] = max_value_i;
      else o[k] = quo_q[k][15:0];
    end
  end
  assign res_o = {o[0], o[1], o[2], level_q, last_q};
endmodule

>>> design/histogram_black_point_clip.sv
// Top level of the histogram black point clip block.
// Depends on hbpc_pkg, hbpc_if, hbpc_ctrl, hbpc_dp.
//
// channel   dir  payload (msb..lsb)
// pix_in    in   action, red_in, green_in, blue_in, last_in (50 bits)
// pix_out   out  red_out, green_out, blue_out, level_used, last_out (65 bits)
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// Histogram pixel: capture, bin read, bin write. Apply pixel: capture, bin
// read, the bit-serial dividers, then the output load once the output is free.
// Last histogram pixel adds a walk over the bins and a clear of all bins.
// After reset the bin memory is cleared before input is taken.
// The result register holds while pix_out.ready is low.
module histogram_black_point_clip #(
  parameter int unsigned HistBinsP  = hbpc_pkg::HistBins,
  parameter int unsigned MaxPixelsP = hbpc_pkg::MaxPixels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hbpc_if.sink        pix_in,
  hbpc_if.source      pix_out,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import hbpc_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [15:0] frac_q, max_q;
  logic [64:0] res, out_q;
  logic        ov_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin frac_q <= '0; max_q <= 16'hFFFF; end
    else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFraction: frac_q <= cfg_data_i;
        RegMaxValue: max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hbpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(pix_in.valid), .in_ready_o(pix_in.ready),
    .out_free_i(!ov_q || pix_out.ready), .sts_i(sts), .cmd_o(cmd)
  );

  hbpc_dp #(.HistBinsP(HistBinsP), .MaxPixelsP(MaxPixelsP)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .fraction_i(frac_q),
    .max_value_i(max_q), .in_data_i(pix_in.data), .res_o(res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd.out_load) ov_q <= 1'b1;
    else if (pix_out.ready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) if (cmd.out_load) out_q <= res;
  assign pix_out.valid = ov_q;
  assign pix_out.data  = out_q;
endmodule

>>> design/hbpc_checker.sv
// Port-level assertions for the histogram black point clip block.
// Depends on hbpc_if and the top level.
module hbpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [64:0] out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_noready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("valid in reset");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown(out_data)) else $error("unknown output data");
endmodule

bind histogram_black_point_clip hbpc_checker u_chk (
  .clk_i, .rst_ni, .in_valid(pix_in.valid), .in_ready(pix_in.ready),
  .out_valid(pix_out.valid), .out_ready(pix_out.ready), .out_data(pix_out.data)
);
